// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ipal_pkg.sv -----
// types, constants and helper functions for the ipv4 prefix allow list
package ipal_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam logic [5:0] PLEN_MAX = 6'd32;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CHECK = 2'd2
    } ipal_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } ipal_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [5:0]  prefix_length;
    } ipal_req_t;

    typedef struct packed {
        logic        allowed;
        logic        status;
        logic [6:0]  entry_count;
        logic [5:0]  match_index;
    } ipal_rsp_t;

    // one table entry as stored in the memory
    typedef struct packed {
        logic [5:0]  plen;
        logic [31:0] net;
    } ipal_entry_t;

    localparam int ENTRY_W = $bits(ipal_entry_t);

    // leading-ones network mask for a prefix length of 0 to 32
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] mask;
        if (len == 6'd0)
        begin
            mask = 32'h0000_0000;
        end
        else if (len >= PLEN_MAX)
        begin
            mask = 32'hffff_ffff;
        end
        else
        begin
            mask = ~(32'hffff_ffff >> len);
        end
        return mask;
    endfunction

endpackage

// ----- src/ipal_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module ipal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/ipv4_prefix_allow_list.sv -----
// top level of the ipv4 prefix allow list: command decode, table scan and config port
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  command   | start / busy           | request (command, address, prefix_length)
//  result    | done (one-cycle pulse) | result (allowed, status, entry_count, match_index)
//  config    | apb psel/penable       | enable at byte address 0
//
// clear, add, unused commands and checks that need no scan answer in the cycle after acceptance.
// a check against a table of n entries reads one entry per cycle from the entry ram and answers
// on the first hit or after the last entry; busy is high during the scan.
// the entry ram needs no clearing after reset: only entries below the fill count are used.
// done is a single-cycle strobe; the receiver cannot stall the block.
module ipv4_prefix_allow_list
    import ipal_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ipal_req_t   request,
    output logic        done,
    output ipal_rsp_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    ipal_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic          enable_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0]   addr_reg, addr_next;
    ipal_rsp_t     rsp_reg, rsp_next;

    logic          accept;
    logic          full;
    logic [5:0]    plen_sat;
    logic          ram_we;
    ipal_entry_t   ram_wdata;
    ipal_entry_t   ram_rdata;
    logic [AW-1:0] ram_raddr;
    logic          hit;
    logic          last;
    logic          cfg_write;

    assign accept = start && (state_reg == ST_IDLE);
    assign full = (count_reg == CW'(MAX_ENTRIES));
    assign plen_sat = (request.prefix_length > PLEN_MAX) ? PLEN_MAX : request.prefix_length;

    assign ram_we = accept && (request.command == CMD_ADD) && !full;
    assign ram_wdata.plen = plen_sat;
    assign ram_wdata.net = request.address & prefix_mask(plen_sat);

    // in idle the ram reads entry 0 so a scan starts with data in hand
    assign ram_raddr = (state_reg == ST_SCAN) ? (idx_reg + AW'(1)) : '0;

    ipal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hit = ((addr_reg & prefix_mask(ram_rdata.plen)) == ram_rdata.net);
    assign last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next = 1'b0;
        idx_next = idx_reg;
        addr_next = addr_reg;
        rsp_next = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.allowed = 1'b0;
                    rsp_next.status = 1'b0;
                    rsp_next.match_index = 6'd0;
                    done_next = 1'b1;
                    case (request.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (!enable_reg)
                            begin
                                rsp_next.allowed = 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                done_next = 1'b0;
                                state_next = ST_SCAN;
                                idx_next = '0;
                                addr_next = request.address;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    rsp_next.entry_count = 7'(count_next);
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    rsp_next.allowed = 1'b1;
                    rsp_next.match_index = 6'(idx_reg);
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (last)
                begin
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg <= 1'b0;
            enable_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg <= done_next;
            if (cfg_write)
            begin
                enable_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        addr_reg <= addr_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign result = rsp_reg;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, enable_reg};

endmodule

// ----- src/ipal_checker.sv -----
// port-level assertions for the ipv4 prefix allow list, bound to the top level
`include "assert_macros.svh"

module ipal_checker
    import ipal_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input ipal_req_t request,
    input logic      done,
    input ipal_rsp_t result
);

    logic take_item;
    logic take_check;
    logic take_clear;
    logic empty_answer;

    assign take_item = start && !busy;
    assign take_check = take_item && (request.command == CMD_CHECK);
    assign take_clear = take_item && (request.command == CMD_CLEAR);
    assign empty_answer = done && (result.entry_count == 7'd0);

    // a result never shows while a scan is still running
    `ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

    // an item other than a check answers in the next cycle
    `ASSERT_NEXT(a_quick_answer, take_item && !take_check, done, "no quick result")

    // a clear leaves an empty table
    `ASSERT_NEXT(a_clear_empty, take_clear, empty_answer, "clear did not empty the table")

    // a dropped add never reports an allowed address
    `ASSERT_NOW(a_status_only_add, done && result.status, !result.allowed, "full with allowed")

    // busy only rises after a start request
    `ASSERT_NOW(a_busy_cause, $rose(busy), $past(start), "busy rose without an accepted item")

endmodule

bind ipv4_prefix_allow_list ipal_checker u_ipal_checker (.*);
